>>> src/palette_pixel_colorize_assert.svh
// ---------------------------------------------------------------------------
// palette_pixel_colorize_assert.svh
// assertion macros used by the colorizer rtl
// ---------------------------------------------------------------------------
`ifndef PALETTE_PIXEL_COLORIZE_ASSERT_SVH
`define PALETTE_PIXEL_COLORIZE_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define PPC_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define PPC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> src/ppc_pkg.sv
// ---------------------------------------------------------------------------
// ppc_pkg
// types, codes and helpers of the palette pixel colorizer
// ---------------------------------------------------------------------------
package ppc_pkg;

  localparam int unsigned PaletteDepth = 192;
  localparam int unsigned PalAddrW     = $clog2(PaletteDepth);
  localparam int unsigned NumSlots     = 4;
  localparam int unsigned CfgIndexW    = 3;
  localparam int unsigned CfgDataW     = 32;

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_COLORIZE = 1'b1;

  typedef enum logic [CfgIndexW-1:0] {
    REG_MAT_COLOR_0     = 3'd0,
    REG_MAT_COLOR_1     = 3'd1,
    REG_MAT_COLOR_2     = 3'd2,
    REG_MAT_COLOR_3     = 3'd3,
    REG_MAT_ALPHAS      = 3'd4,
    REG_BASE_ALPHA      = 3'd5,
    REG_TRANSPARENT_KEY = 3'd6
  } cfg_reg_t;

  localparam logic [15:0] TransparentKeyReset = 16'hF81F;
  localparam logic [7:0]  AlphaOpaque         = 8'hFF;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic [7:0]  pixel_alpha;
    logic        alpha_in_use;
  } out_word_t;

  typedef struct packed {
    logic [NumSlots-1:0][15:0] material_color;
    logic [NumSlots-1:0][7:0]  material_alphas;
    logic [7:0]                base_alpha;
    logic [15:0]               transparent_key;
  } cfg_regs_t;

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

>>> src/ppc_stream_if.sv
// ---------------------------------------------------------------------------
// ppc_stream_if
// valid/ready channel carrying one word per handshake
// ---------------------------------------------------------------------------
interface ppc_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/ppc_palette_mem.sv
// ---------------------------------------------------------------------------
// ppc_palette_mem
// palette table, one write port and one registered read port
// ---------------------------------------------------------------------------
module ppc_palette_mem (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [ppc_pkg::PalAddrW-1:0]    wr_addr,
  input  logic [15:0]                     wr_data,
  input  logic                            rd_en,
  input  logic [ppc_pkg::PalAddrW-1:0]    rd_addr,
  output logic [15:0]                     rd_data
);

  logic [15:0] mem [ppc_pkg::PaletteDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/ppc_colorize.sv
// ---------------------------------------------------------------------------
// ppc_colorize
// result word for one pixel: palette colour, transparent key or shaded material colour
// ---------------------------------------------------------------------------
module ppc_colorize (
  input  logic [7:0]          pixel_index,
  input  logic [15:0]         pal_data,
  input  ppc_pkg::cfg_regs_t  cfg,
  output ppc_pkg::out_word_t  word
);

  function automatic logic [7:0] shade_chan(input logic [7:0] chan8, input logic [3:0] shade);
    logic [11:0] prod;
    logic [8:0]  scaled;
    prod   = chan8 * shade;
    scaled = prod[11:3];
    return scaled[8] ? 8'hFF : scaled[7:0];
  endfunction

  logic        is_material;
  logic [1:0]  slot;
  logic [3:0]  shade;
  logic [15:0] col;
  logic        col_is_key;
  logic [7:0]  r8, g8, b8;

  // indices 192..255: top two bits set, slot in bits 5:4
  assign is_material = (pixel_index[7:6] == 2'b11);
  assign slot        = pixel_index[5:4];
  assign shade       = pixel_index[3:0];
  assign col         = cfg.material_color[slot];
  assign col_is_key  = (col == cfg.transparent_key);

  assign r8 = shade_chan({col[15:11], 3'b000}, shade);
  assign g8 = shade_chan({col[10:5], 2'b00}, shade);
  assign b8 = shade_chan({col[4:0], 3'b000}, shade);

  always_comb begin
    word.alpha_in_use = (cfg.base_alpha != ppc_pkg::AlphaOpaque) ||
                        (cfg.material_alphas != {ppc_pkg::NumSlots{ppc_pkg::AlphaOpaque}});
    word.pixel_alpha  = cfg.base_alpha;
    word.pixel_rgb565 = pal_data;
    if (is_material) begin
      if (col_is_key) begin
        word.pixel_rgb565 = cfg.transparent_key;
      end else begin
        word.pixel_rgb565 = ppc_pkg::pack565(r8, g8, b8);
        word.pixel_alpha  = cfg.material_alphas[slot];
      end
    end
  end

endmodule

>>> src/palette_pixel_colorize.sv
// ---------------------------------------------------------------------------
// palette_pixel_colorize
// palette index stream to rgb565 pixels with alpha
// ---------------------------------------------------------------------------
// pix_in takes one word per handshake: opcode OP_WRITE stores an rgb888
// entry (converted to rgb565) at pixel_index when below 192 and gives no
// output word; OP_COLORIZE gives exactly one word on pix_out.
// The cfg port writes the material colours, alphas, base alpha and the
// transparent key; write it only while no word is in flight.
// A colorize word passes the palette read register, then the output register,
// before it is offered on pix_out.
// Throughput: one word per cycle while pix_out does not stall; each stage holds
// one word and the palette is written or read at most once per accepted word.
// Reset clears the pipeline valid flags and loads the register defaults;
// the palette table is not cleared and must be written before it is read.
// When pix_out stalls, the output and input stage hold their words and
// pix_in.ready drops once both stages are full; nothing is dropped.
// ---------------------------------------------------------------------------
`include "palette_pixel_colorize_assert.svh"

module palette_pixel_colorize (
  input  logic                               clk,
  input  logic                               rst,
  ppc_stream_if.sink                         pix_in,
  ppc_stream_if.source                       pix_out,
  input  logic                               cfg_wr_en,
  input  logic [ppc_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [ppc_pkg::CfgDataW-1:0]       cfg_data
);

  ppc_pkg::cfg_regs_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.material_color  <= '0;
      cfg.material_alphas <= {ppc_pkg::NumSlots{ppc_pkg::AlphaOpaque}};
      cfg.base_alpha      <= ppc_pkg::AlphaOpaque;
      cfg.transparent_key <= ppc_pkg::TransparentKeyReset;
    end else if (cfg_wr_en) begin
      case (ppc_pkg::cfg_reg_t'(cfg_index))
        ppc_pkg::REG_MAT_COLOR_0:     cfg.material_color[0] <= cfg_data[15:0];
        ppc_pkg::REG_MAT_COLOR_1:     cfg.material_color[1] <= cfg_data[15:0];
        ppc_pkg::REG_MAT_COLOR_2:     cfg.material_color[2] <= cfg_data[15:0];
        ppc_pkg::REG_MAT_COLOR_3:     cfg.material_color[3] <= cfg_data[15:0];
        ppc_pkg::REG_MAT_ALPHAS:      cfg.material_alphas   <= cfg_data;
        ppc_pkg::REG_BASE_ALPHA:      cfg.base_alpha        <= cfg_data[7:0];
        ppc_pkg::REG_TRANSPARENT_KEY: cfg.transparent_key   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic out_valid;
  logic s1_valid;
  logic s1_valid_next;
  logic out_take;
  logic s1_free;
  logic in_accept;
  logic is_write;
  logic in_pal;
  logic both_full;

  assign out_take  = !out_valid || pix_out.ready;
  assign s1_free   = !s1_valid || out_take;
  assign in_accept = pix_in.valid && s1_free;
  assign is_write  = (pix_in.payload.opcode == ppc_pkg::OP_WRITE);
  assign in_pal    = (pix_in.payload.pixel_index < 8'(ppc_pkg::PaletteDepth));
  assign both_full = s1_valid && out_valid && !pix_out.ready;

  assign pix_in.ready = s1_free;

  always_comb begin
    s1_valid_next = s1_valid && !out_take;
    if (in_accept) begin
      s1_valid_next = !is_write;
    end
  end

  // stage 1: palette access and index register
  logic [7:0]  s1_index;
  logic [15:0] pal_data;

  ppc_palette_mem u_mem (
    .clk     (clk),
    .wr_en   (in_accept && is_write && in_pal),
    .wr_addr (pix_in.payload.pixel_index[ppc_pkg::PalAddrW-1:0]),
    .wr_data (ppc_pkg::pack565(pix_in.payload.entry_red, pix_in.payload.entry_green,
                               pix_in.payload.entry_blue)),
    .rd_en   (in_accept && !is_write && in_pal),
    .rd_addr (pix_in.payload.pixel_index[ppc_pkg::PalAddrW-1:0]),
    .rd_data (pal_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && !is_write) begin
      s1_index <= pix_in.payload.pixel_index;
    end
  end

  // stage 2: result register
  ppc_pkg::out_word_t result;
  ppc_pkg::out_word_t out_word;

  ppc_colorize u_colorize (
    .pixel_index (s1_index),
    .pal_data    (pal_data),
    .cfg         (cfg),
    .word        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      out_word <= result;
    end
  end

  assign pix_out.valid   = out_valid;
  assign pix_out.payload = out_word;

  `PPC_ASSERT_NEXT(a_write_no_word, clk, rst, in_accept && is_write, !s1_valid, "stray write")
  `PPC_ASSERT_NEXT(a_colorize_held, clk, rst, in_accept && !is_write, s1_valid, "word lost")
  `PPC_ASSERT_NEXT(a_stall_keeps_s1, clk, rst, both_full, s1_valid, "stage 1 word dropped")
  `PPC_ASSERT_NOW(a_full_blocks_in, clk, rst, both_full, !pix_in.ready, "input taken while full")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// palette pixel colorizer: palette loads, palette reads and shaded material
// pixels under several register settings, with random gaps on both streams,
// checked word by word against a behavioral model of the colorizer
// ---------------------------------------------------------------------------
module testbench;
  import ppc_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 150;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ppc_stream_if #(.word_t(in_word_t)) pix_in_ch ();
  ppc_stream_if #(.word_t(out_word_t)) pix_out_ch ();

  palette_pixel_colorize u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in_ch),
    .pix_out   (pix_out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // colorizer model state
  cfg_regs_t   cfg_model;
  logic [15:0] palette_model [PaletteDepth];
  out_word_t   expected_pixels [$];

  // stimulus side
  in_word_t in_words_q [$];
  bit       entry_loaded [PaletteDepth];
  bit       steady;
  bit       in_fire;
  bit       hold_done;
  int       hold_left;
  int       quiet_cycles;
  int       mismatches;
  int       pixels_checked;
  int       writes_sent;
  int       colorize_sent;
  int       settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] to_rgb565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [7:0] shade_chan(input logic [7:0] c, input logic [3:0] s);
    logic [11:0] p;
    p = c * s;
    p = p >> 3;
    return (p > 12'd255) ? 8'd255 : p[7:0];
  endfunction

  task automatic predict_pixel(input in_word_t w);
    logic [1:0]  slot;
    logic [15:0] col;
    out_word_t   px;
    if (w.opcode == OP_WRITE) begin
      if (w.pixel_index < PaletteDepth)
        palette_model[w.pixel_index] = to_rgb565(w.entry_red, w.entry_green, w.entry_blue);
    end else begin
      px.alpha_in_use = (cfg_model.base_alpha != AlphaOpaque) ||
                        (cfg_model.material_alphas != {NumSlots{AlphaOpaque}});
      px.pixel_alpha = cfg_model.base_alpha;
      if (w.pixel_index >= PaletteDepth) begin
        // 192..255: slot in bits 5:4, shade in bits 3:0
        slot = w.pixel_index[5:4];
        col = cfg_model.material_color[slot];
        if (col != cfg_model.transparent_key) begin
          px.pixel_rgb565 = to_rgb565(shade_chan({col[15:11], 3'b000}, w.pixel_index[3:0]),
                                      shade_chan({col[10:5], 2'b00}, w.pixel_index[3:0]),
                                      shade_chan({col[4:0], 3'b000}, w.pixel_index[3:0]));
          px.pixel_alpha = cfg_model.material_alphas[slot];
        end else begin
          px.pixel_rgb565 = cfg_model.transparent_key;
        end
      end else begin
        px.pixel_rgb565 = palette_model[w.pixel_index];
      end
      expected_pixels = {expected_pixels, px};
    end
  endtask

  task automatic check_pixel(input out_word_t got);
    out_word_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected output word %h", got);
      mismatches++;
    end else begin
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (got.pixel_rgb565 !== want.pixel_rgb565) begin
        $error("pixel_rgb565: expected %h, actual %h", want.pixel_rgb565, got.pixel_rgb565);
        mismatches++;
      end
      if (got.pixel_alpha !== want.pixel_alpha) begin
        $error("pixel_alpha: expected %h, actual %h", want.pixel_alpha, got.pixel_alpha);
        mismatches++;
      end
      if (got.alpha_in_use !== want.alpha_in_use) begin
        $error("alpha_in_use: expected %b, actual %b", want.alpha_in_use, got.alpha_in_use);
        mismatches++;
      end
    end
  endtask

  // driver: a new word only once the current one is gone
  always @(negedge clk) begin
    if (rst) begin
      pix_in_ch.valid <= 1'b0;
    end else if (!pix_in_ch.valid || in_fire) begin
      if (in_words_q.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
        pix_in_ch.payload <= in_words_q.pop_front();
        pix_in_ch.valid <= 1'b1;
      end else begin
        pix_in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off while words are still queued
  always @(negedge clk) begin
    if (rst) begin
      pix_out_ch.ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      pix_out_ch.ready <= 1'b0;
    end else if (!hold_done && pixels_checked >= 300 && in_words_q.size() > 20) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      pix_out_ch.ready <= 1'b0;
    end else begin
      pix_out_ch.ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_fire <= pix_in_ch.valid && pix_in_ch.ready;
      if (pix_out_ch.valid && pix_out_ch.ready)
        check_pixel(pix_out_ch.payload);
      if (pix_in_ch.valid && pix_in_ch.ready)
        predict_pixel(pix_in_ch.payload);
      if ((pix_out_ch.valid && pix_out_ch.ready) || (pix_in_ch.valid && pix_in_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic add_word(input logic op, input logic [7:0] idx, input logic [7:0] r,
                          input logic [7:0] g, input logic [7:0] b);
    in_word_t w;
    w = {op, idx, r, g, b};
    in_words_q = {in_words_q, w};
    if (op == OP_WRITE) begin
      writes_sent++;
      if (idx < PaletteDepth)
        entry_loaded[idx] = 1'b1;
    end else begin
      colorize_sent++;
    end
  endtask

  task automatic queue_random(input int n);
    int done;
    int roll;
    logic [7:0] idx;
    logic [15:0] key;
    done = 0;
    key = cfg_model.transparent_key;
    while (done < n) begin
      roll = $urandom_range(99);
      idx = 8'($urandom_range(255));
      if (roll < 5) begin
        // writes past the table are dropped by the block
        add_word(OP_WRITE, 8'($urandom_range(255, PaletteDepth)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (roll < 10) begin
        // entry that packs to the transparent key
        add_word(OP_WRITE, 8'($urandom_range(PaletteDepth - 1)),
                 {key[15:11], 3'($urandom_range(7))}, {key[10:5], 2'($urandom_range(3))},
                 {key[4:0], 3'($urandom_range(7))});
        done++;
      end else if (roll < 30 || (idx < PaletteDepth && !entry_loaded[idx])) begin
        add_word(OP_WRITE, (roll < 30) ? 8'($urandom_range(PaletteDepth - 1)) : idx,
                 8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
        done++;
      end else begin
        add_word(OP_COLORIZE, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
        done++;
      end
    end
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CfgDataW-1:0] d);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    case (r)
      REG_MAT_COLOR_0, REG_MAT_COLOR_1, REG_MAT_COLOR_2, REG_MAT_COLOR_3: begin
        cfg_model.material_color[r[1:0]] = d[15:0];
      end
      REG_MAT_ALPHAS: begin
        cfg_model.material_alphas = d;
      end
      REG_BASE_ALPHA: begin
        cfg_model.base_alpha = d[7:0];
      end
      REG_TRANSPARENT_KEY: begin
        cfg_model.transparent_key = d[15:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic program_regs(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [15:0] c2, input logic [15:0] c3,
                              input logic [31:0] alphas, input logic [7:0] base,
                              input logic [15:0] key);
    write_reg(REG_MAT_COLOR_0, CfgDataW'(c0));
    write_reg(REG_MAT_COLOR_1, CfgDataW'(c1));
    write_reg(REG_MAT_COLOR_2, CfgDataW'(c2));
    write_reg(REG_MAT_COLOR_3, CfgDataW'(c3));
    write_reg(REG_MAT_ALPHAS, alphas);
    write_reg(REG_BASE_ALPHA, CfgDataW'(base));
    write_reg(REG_TRANSPARENT_KEY, CfgDataW'(key));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // wait until every word is through, then let the pipeline empty out
  task automatic settle();
    do @(posedge clk);
    while (in_words_q.size() != 0 || pix_in_ch.valid || expected_pixels.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] key;
    logic [15:0] mc [NumSlots];
    logic [31:0] alphas;
    logic [7:0]  base;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in_ch.valid = 1'b0;
    pix_in_ch.payload = '0;
    pix_out_ch.ready = 1'b1;
    steady = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    mismatches = 0;
    pixels_checked = 0;
    writes_sent = 0;
    colorize_sent = 0;
    settings_used = 1;
    cfg_model.material_color = '0;
    cfg_model.material_alphas = {NumSlots{AlphaOpaque}};
    cfg_model.base_alpha = AlphaOpaque;
    cfg_model.transparent_key = TransparentKeyReset;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // register defaults: palette extremes, key-colored entry, dropped writes
    add_word(OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
    add_word(OP_WRITE, 8'd191, 8'hFF, 8'hFF, 8'hFF);
    add_word(OP_WRITE, 8'd1, 8'hFF, 8'h00, 8'hFF);
    add_word(OP_WRITE, 8'd2, 8'hA5, 8'h5A, 8'h3C);
    add_word(OP_WRITE, 8'd192, 8'h12, 8'h34, 8'h56);
    add_word(OP_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    add_word(OP_COLORIZE, 8'd0, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd1, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd2, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd191, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd192, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd207, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd255, 8'h00, 8'h00, 8'h00);
    settle();

    // saturating white, tiny color, transparent slot 2, mixed alphas
    program_regs(16'hFFFF, 16'h0821, TransparentKeyReset, 16'h7BEF, 32'h4000_80FE, 8'h00,
                 TransparentKeyReset);
    add_word(OP_COLORIZE, 8'd192, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd200, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd207, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd208, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd223, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd224, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd239, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd240, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd255, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd1, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd0, 8'h00, 8'h00, 8'h00);
    add_word(OP_COLORIZE, 8'd191, 8'h00, 8'h00, 8'h00);
    settle();

    // all registers at zero, then all at their maximum
    program_regs('0, '0, '0, '0, '0, '0, '0);
    queue_random(140);
    settle();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    queue_random(140);
    settle();

    for (int p = 0; p < 6; p++) begin
      key = ($urandom_range(3) == 0) ? TransparentKeyReset : 16'($urandom_range(16'hFFFF));
      for (int s = 0; s < NumSlots; s++)
        mc[s] = ($urandom_range(4) == 0) ? key : 16'($urandom_range(16'hFFFF));
      alphas = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF : $urandom();
      base = ($urandom_range(2) == 0) ? AlphaOpaque : 8'($urandom_range(255));
      program_regs(mc[0], mc[1], mc[2], mc[3], alphas, base, key);
      // one setting runs with both streams never idling
      steady = (p == 2);
      queue_random(140);
      settle();
      steady = 1'b0;
    end

    repeat (10) @(posedge clk);
    $display("covered %0d palette writes and %0d colorize words under %0d register settings",
             writes_sent, colorize_sent, settings_used);
    $display("%0d output words compared, %0d field mismatches", pixels_checked, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> palette_pixel_colorize.f
+incdir+src
src/ppc_pkg.sv
src/ppc_stream_if.sv
src/ppc_palette_mem.sv
src/ppc_colorize.sv
src/palette_pixel_colorize.sv
tb/testbench.sv
